FILE: sv/sfl_pkg.sv
package sfl_pkg;

    localparam int DELAY_DEPTH = 1024;
    localparam int SINE_DEPTH  = 1024;

    localparam int SAMPLE_W = 16;
    localparam int POT_W    = 10;
    localparam int MOD_W    = 13;
    localparam int TAP_W    = MOD_W - 8;
    localparam int FRAC_W   = 8;
    localparam int PHASE_W  = $clog2(SINE_DEPTH);

    localparam int          QUARTER_DEPTH = SINE_DEPTH / 4;
    localparam int          HALF_SHIFT    = $clog2(SINE_DEPTH / 2);
    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam int          AMPLITUDE     = 32767;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [POT_W-1:0]    pot_t;
    typedef logic signed [MOD_W-1:0]    mod_t;
    typedef logic        [FRAC_W-1:0]   frac_t;
    typedef logic signed [TAP_W-1:0]    tap_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        tap_t tap;
    } dly_ctrl_t;

    typedef logic [QUARTER_DEPTH-1:0][SAMPLE_W-2:0] quarter_table_t;

    // Q30 Taylor series of sin on the first quarter wave, evaluated at elaboration.
    function automatic logic [SAMPLE_W-2:0] quarter_sine(input logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        int                 n;
        x    = (r * PI_Q30 + (64'd1 << (HALF_SHIFT - 1))) >> HALF_SHIFT;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 9; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                default: term = term / 64'd342;
            endcase
            if ((n % 2) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > AMPLITUDE)
            v = AMPLITUDE;
        return v[SAMPLE_W-2:0];
    endfunction

    function automatic quarter_table_t build_quarter_table();
        quarter_table_t t;
        int             k;
        for (k = 0; k < QUARTER_DEPTH; k++)
            t[k] = quarter_sine(64'(k));
        return t;
    endfunction

    localparam quarter_table_t QUARTER_TABLE = build_quarter_table();

endpackage

FILE: sv/sfl_if.sv
interface sfl_in_if;
    import sfl_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;
    pot_t    depth_pot;
    pot_t    rate_pot;

    modport source (
        output valid, left_sample, right_sample, depth_pot, rate_pot,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, depth_pot, rate_pot,
        output ready
    );
endinterface

interface sfl_out_if;
    import sfl_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_result;
    sample_t right_result;

    modport source (
        output valid, left_result, right_result,
        input  ready
    );
    modport sink (
        input  valid, left_result, right_result,
        output ready
    );
endinterface

FILE: sv/sfl_lfo.sv
module sfl_lfo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          mod_en,
    input  sfl_pkg::pot_t depth_pot,
    input  sfl_pkg::pot_t rate_pot,
    output sfl_pkg::mod_t mod
);
    import sfl_pkg::*;

    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    sample_t              sine_reg;
    sample_t              sine_next;
    pot_t                 depth_reg;
    mod_t                 mod_reg;
    logic [1:0]           quad;
    logic [PHASE_W-3:0]   r;
    logic [PHASE_W-2:0]   idx;
    logic [SAMPLE_W-2:0]  mag;
    logic signed [POT_W+3:0]            depth8;
    logic signed [SAMPLE_W+POT_W+3:0]   prod;

    assign quad = phase_reg[PHASE_W-1:PHASE_W-2];
    assign r    = phase_reg[PHASE_W-3:0];
    // odd quadrants run the quarter table backwards
    assign idx  = quad[0] ? ((PHASE_W-1)'(QUARTER_DEPTH) - {1'b0, r}) : {1'b0, r};

    always_comb
    begin
        if (idx[PHASE_W-2])
            mag = (SAMPLE_W-1)'(AMPLITUDE);
        else
            mag = QUARTER_TABLE[idx[PHASE_W-3:0]];
        sine_next = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign phase_next = phase_reg + PHASE_W'(1) + PHASE_W'(rate_pot[POT_W-1:POT_W-2]);
    assign depth8     = $signed({1'b0, depth_reg, 3'b000});
    assign prod       = sine_reg * depth8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sine_reg  <= sine_next;
            depth_reg <= depth_pot;
        end
        if (mod_en)
            mod_reg <= prod[MOD_W+15:16];
    end

    assign mod = mod_reg;

endmodule

FILE: sv/sfl_delay.sv
module sfl_delay (
    input  logic               clk,
    input  logic               rst_n,
    input  sfl_pkg::dly_ctrl_t ctrl,
    input  sfl_pkg::sample_t   wr_data,
    output sfl_pkg::sample_t   rd_a,
    output sfl_pkg::sample_t   rd_b
);
    import sfl_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = $clog2(DELAY_DEPTH + 1);

    sample_t         mem [DELAY_DEPTH];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   wp_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic [AW:0]     tap_sum;
    logic [AW-1:0]   addr_a;
    logic [AW-1:0]   addr_b;
    sample_t         a_q_reg;
    sample_t         b_q_reg;
    logic            a_vld_reg;
    logic            b_vld_reg;

    assign wp_next   = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign fill_next = (fill_reg == FW'(DELAY_DEPTH)) ? fill_reg : fill_reg + FW'(1);

    // tap lies half a buffer behind the write pointer; sum stays below twice the depth
    assign tap_sum = {1'b0, wp_reg} + (AW+1)'(DELAY_DEPTH / 2)
                   + {{(AW+1-TAP_W){ctrl.tap[TAP_W-1]}}, ctrl.tap};
    assign addr_a  = (tap_sum >= (AW+1)'(DELAY_DEPTH))
                   ? AW'(tap_sum - (AW+1)'(DELAY_DEPTH)) : tap_sum[AW-1:0];
    assign addr_b  = (addr_a == AW'(DELAY_DEPTH - 1)) ? '0 : addr_a + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            // entries at or above the fill count were never written since reset
            if (ctrl.rd_en)
            begin
                a_vld_reg <= FW'(addr_a) < fill_reg;
                b_vld_reg <= FW'(addr_b) < fill_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[wp_reg] <= wr_data;
        if (ctrl.rd_en)
        begin
            a_q_reg <= mem[addr_a];
            b_q_reg <= mem[addr_b];
        end
    end

    assign rd_a = a_vld_reg ? a_q_reg : '0;
    assign rd_b = b_vld_reg ? b_q_reg : '0;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DELAY_DEPTH))
        else $error("fill count beyond delay depth");

    a_wr_rd_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> !ctrl.rd_en)
        else $error("delay write and tap read in the same cycle");

    // the write that fills the last entry wraps the pointer to zero
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en && fill_reg != FW'(DELAY_DEPTH)
            |=> fill_reg == FW'(wp_reg) || fill_reg == FW'(DELAY_DEPTH))
        else $error("fill count and write pointer disagree while filling");

endmodule

FILE: sv/stereo_flanger.sv
// Stereo flanger: each accepted beat carries one stereo sample pair plus the depth and
// rate pot readings; one result beat follows with both channels, half dry plus half of
// the interpolated, LFO-modulated mono delay tap. An item holds the sequencer through
// accept (sine table read, delay-line write), LFO depth multiply, two-port delay read,
// interpolation into the output register; the result beat is valid once S_MIX loads
// it. A new beat is taken once the sequencer is back in idle, even while the previous
// result still waits downstream; the mix step stalls while it does. The delay line is a
// 1024-entry memory; after reset it reads as zero wherever it has not been written,
// tracked by a fill count, so there is no clearing pass and the block is ready at once.
module stereo_flanger (
    input logic clk,
    input logic rst_n,
    sfl_in_if.sink    samples,
    sfl_out_if.source results
);
    import sfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_MIX
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    sample_t   left_result_reg;
    sample_t   right_result_reg;
    sample_t   left_half_reg;
    sample_t   right_half_reg;
    logic      accept;
    logic      load_out;
    sample_t   left_half;
    sample_t   right_half;
    sample_t   mono;
    mod_t      mod;
    dly_ctrl_t dly_ctrl;
    sample_t   tap_a;
    sample_t   tap_b;
    frac_t     frac;
    frac_t     wgt_a;
    logic signed [SAMPLE_W+FRAC_W:0] prod_a;
    logic signed [SAMPLE_W+FRAC_W:0] prod_b;
    sample_t   wet;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;

    assign left_half  = {samples.left_sample[SAMPLE_W-1], samples.left_sample[SAMPLE_W-1:1]};
    assign right_half = {samples.right_sample[SAMPLE_W-1], samples.right_sample[SAMPLE_W-1:1]};
    assign mono       = left_half + right_half;

    sfl_lfo u_lfo (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .mod_en    (state_reg == S_MOD),
        .depth_pot (samples.depth_pot),
        .rate_pot  (samples.rate_pot),
        .mod       (mod)
    );

    assign dly_ctrl.wr_en = accept;
    assign dly_ctrl.rd_en = (state_reg == S_READ);
    assign dly_ctrl.tap   = mod[MOD_W-1:FRAC_W];

    sfl_delay u_delay (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dly_ctrl),
        .wr_data (mono),
        .rd_a    (tap_a),
        .rd_b    (tap_b)
    );

    // linear blend of the two neighbors, each term floored by 2^9
    assign frac   = mod[FRAC_W-1:0];
    assign wgt_a  = FRAC_W'(8'hff) - frac;
    assign prod_a = tap_a * $signed({1'b0, wgt_a});
    assign prod_b = tap_b * $signed({1'b0, frac});
    assign wet    = prod_a[SAMPLE_W+8:9] + prod_b[SAMPLE_W+8:9];

    assign load_out = (state_reg == S_MIX) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_MOD;
            end
            S_MOD:  state_next = S_READ;
            S_READ: state_next = S_MIX;
            S_MIX:
            begin
                if (load_out)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_half_reg  <= left_half;
            right_half_reg <= right_half;
        end
        if (load_out)
        begin
            left_result_reg  <= left_half_reg + wet;
            right_result_reg <= right_half_reg + wet;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.left_result  = left_result_reg;
    assign results.right_result = right_result_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MOD)
        else $error("accepted beat did not start the sequence");

    a_load_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_MIX))
        else $error("result loaded outside the mix step");

    a_mix_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MIX && !$past(state_reg == S_MIX) && !out_valid_reg
            |=> state_reg == S_IDLE && out_valid_reg)
        else $error("mix step did not hand over to a free output register");

endmodule
